// File: design/mi3_pkg.sv
// mi3_pkg: shared types and constants of the 3x3 matrix inverse pipeline
// no dependencies; imported by every module of the block
`default_nettype none
package mi3_pkg;

    // number of matrix elements and operand widths
    localparam int NEL     = 9;
    localparam int IN_W    = 16;
    localparam int COF_W   = 33;
    localparam int DET_W   = 50;
    localparam int DEN_W   = 49;
    localparam int NB_W    = 33;
    localparam int QUO_W   = 33;
    localparam int RES_W   = 32;

    // pipeline depth: cofactor stages, divider prep, one stage per quotient bit, saturation
    localparam int COF_LAT = 4;
    localparam int NSTEP   = QUO_W;
    localparam int DEPTH   = COF_LAT + NSTEP + 2;

    // saturation limits of a Q16.16 result
    localparam logic [RES_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0] SAT_NEG = 32'h8000_0000;
    localparam logic [QUO_W-1:0] NEG_LIM = 33'h0_8000_0000;

    typedef logic [NEL-1:0][IN_W-1:0]  t_mat;
    typedef logic [NEL-1:0][COF_W-1:0] t_cof;
    typedef logic [NEL-1:0][RES_W-1:0] t_res;

    // state of the nine lanes of the shared-denominator divider
    typedef struct packed {
        logic [NEL-1:0][DEN_W-1:0] rem;
        logic [NEL-1:0][NB_W-1:0]  nb;
        logic [NEL-1:0][QUO_W-1:0] quo;
        logic [NEL-1:0]            neg;
        logic [NEL-1:0]            ovf;
        logic [DEN_W-1:0]          den;
        logic                      sing;
    } t_dstage;

endpackage
`default_nettype wire

// File: design/mi3_cofactor.sv
// mi3_cofactor: four register stages forming the adjugate and the determinant
// depends on mi3_pkg
`default_nettype none
module mi3_cofactor import mi3_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_mat i_m,
    output t_cof      o_cof,
    output logic [DET_W-1:0] o_det
);

    logic signed [IN_W-1:0]    w_a   [NEL];
    logic signed [2*IN_W-1:0]  r_p   [2*NEL];
    logic signed [IN_W-1:0]    r_a1  [3];
    logic signed [IN_W-1:0]    r_a2  [3];
    logic signed [COF_W-1:0]   r_cof2 [NEL];
    logic signed [COF_W-1:0]   r_cof3 [NEL];
    logic signed [COF_W-1:0]   r_cof4 [NEL];
    logic signed [DET_W-2:0]   r_dp  [3];
    logic signed [DET_W-1:0]   r_det;

    // signed view of the inputs
    genvar g;
    generate
        for (g = 0; g < NEL; g++) begin : g_in
            assign w_a[g] = $signed(i_m[g]);
        end
    endgenerate

    // stage 1: the eighteen 16x16 products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]  <= w_a[4] * w_a[8];  r_p[1]  <= w_a[5] * w_a[7];
            r_p[2]  <= w_a[2] * w_a[7];  r_p[3]  <= w_a[1] * w_a[8];
            r_p[4]  <= w_a[1] * w_a[5];  r_p[5]  <= w_a[2] * w_a[4];
            r_p[6]  <= w_a[5] * w_a[6];  r_p[7]  <= w_a[3] * w_a[8];
            r_p[8]  <= w_a[0] * w_a[8];  r_p[9]  <= w_a[2] * w_a[6];
            r_p[10] <= w_a[3] * w_a[2];  r_p[11] <= w_a[0] * w_a[5];
            r_p[12] <= w_a[3] * w_a[7];  r_p[13] <= w_a[4] * w_a[6];
            r_p[14] <= w_a[6] * w_a[1];  r_p[15] <= w_a[0] * w_a[7];
            r_p[16] <= w_a[0] * w_a[4];  r_p[17] <= w_a[3] * w_a[1];
            r_a1[0] <= w_a[0];
            r_a1[1] <= w_a[1];
            r_a1[2] <= w_a[2];
        end
    end

    // stage 2: cofactor differences
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NEL; k++) begin
                r_cof2[k] <= $signed({r_p[2*k][2*IN_W-1], r_p[2*k]})
                           - $signed({r_p[2*k+1][2*IN_W-1], r_p[2*k+1]});
            end
            r_a2 <= r_a1;
        end
    end

    // stage 3: first-row expansion products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dp[0] <= r_a2[0] * r_cof2[0];
            r_dp[1] <= r_a2[1] * r_cof2[3];
            r_dp[2] <= r_a2[2] * r_cof2[6];
            r_cof3  <= r_cof2;
        end
    end

    // stage 4: determinant sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det  <= r_dp[0] + r_dp[1] + r_dp[2];
            r_cof4 <= r_cof3;
        end
    end

    generate
        for (g = 0; g < NEL; g++) begin : g_out
            assign o_cof[g] = r_cof4[g];
        end
    endgenerate
    assign o_det = r_det;

endmodule
`default_nettype wire

// File: design/mi3_div_prep.sv
// mi3_div_prep: sign split, magnitudes and quotient overflow check before the divider
// depends on mi3_pkg
`default_nettype none
module mi3_div_prep import mi3_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire t_cof             i_cof,
    input  wire logic [DET_W-1:0] i_det,
    output t_dstage               o_st
);

    t_dstage             n_st;
    t_dstage             r_st;
    logic [DET_W-1:0]    w_dabs;
    logic [COF_W-1:0]    w_mag [NEL];

    // magnitudes; the numerator is the cofactor magnitude shifted up by 24
    always_comb begin
        w_dabs = i_det[DET_W-1] ? DET_W'(-i_det) : i_det;
        n_st   = '0;
        n_st.den  = w_dabs[DEN_W-1:0];
        n_st.sing = (i_det == '0);
        for (int k = 0; k < NEL; k++) begin
            w_mag[k]     = i_cof[k][COF_W-1] ? COF_W'(-i_cof[k]) : i_cof[k];
            n_st.neg[k]  = i_cof[k][COF_W-1] ^ i_det[DET_W-1];
            // quotient of 2^33 or more when the upper numerator bits reach the divisor
            n_st.ovf[k]  = {25'd0, w_mag[k][COF_W-1:9]} >= w_dabs[DEN_W-1:0];
            n_st.rem[k]  = n_st.ovf[k] ? '0 : {25'd0, w_mag[k][COF_W-1:9]};
            n_st.nb[k]   = {w_mag[k][8:0], 24'd0};
            n_st.quo[k]  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule
`default_nettype wire

// File: design/mi3_div_step.sv
// mi3_div_step: one restoring division step for all nine lanes, registered
// depends on mi3_pkg
`default_nettype none
module mi3_div_step import mi3_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_en,
    input  wire t_dstage i_st,
    output t_dstage      o_st
);

    t_dstage          n_st;
    t_dstage          r_st;
    logic [DEN_W:0]   w_sh [NEL];
    logic             w_ge [NEL];

    // shift in the next numerator bit and subtract when it fits
    always_comb begin
        n_st = i_st;
        for (int k = 0; k < NEL; k++) begin
            w_sh[k] = {i_st.rem[k], i_st.nb[k][NB_W-1]};
            w_ge[k] = w_sh[k] >= {1'b0, i_st.den};
            n_st.rem[k] = w_ge[k] ? DEN_W'(w_sh[k] - {1'b0, i_st.den}) : w_sh[k][DEN_W-1:0];
            n_st.nb[k]  = {i_st.nb[k][NB_W-2:0], 1'b0};
            n_st.quo[k] = {i_st.quo[k][QUO_W-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule
`default_nettype wire

// File: design/mi3_sat.sv
// mi3_sat: sign restore, saturation to 32 bits, singular and clip flags
// depends on mi3_pkg
`default_nettype none
module mi3_sat import mi3_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_en,
    input  wire t_dstage i_st,
    output t_res         o_res,
    output logic         o_singular,
    output logic         o_clipped
);

    t_res             n_res;
    t_res             r_res;
    logic [NEL-1:0]   w_clip;
    logic             r_singular;
    logic             r_clipped;

    // per lane: clip to the signed 32-bit range, zero everything when singular
    always_comb begin
        for (int k = 0; k < NEL; k++) begin
            if (i_st.neg[k]) begin
                w_clip[k] = i_st.ovf[k] || (i_st.quo[k] > NEG_LIM);
                n_res[k]  = w_clip[k] ? SAT_NEG : RES_W'(-i_st.quo[k][RES_W-1:0]);
            end else begin
                w_clip[k] = i_st.ovf[k] || (i_st.quo[k][QUO_W-1:RES_W-1] != 2'b00);
                n_res[k]  = w_clip[k] ? SAT_POS : i_st.quo[k][RES_W-1:0];
            end
            if (i_st.sing) begin
                w_clip[k] = 1'b0;
                n_res[k]  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res      <= n_res;
            r_singular <= i_st.sing;
            r_clipped  <= |w_clip;
        end
    end

    assign o_res      = r_res;
    assign o_singular = r_singular;
    assign o_clipped  = r_clipped;

endmodule
`default_nettype wire

// File: design/matrix_3x3_inverse_core.sv
// matrix_3x3_inverse_core: top level of the 3x3 matrix inverse pipeline
// depends on mi3_pkg, mi3_cofactor, mi3_div_prep, mi3_div_step, mi3_sat
//
// usage:
//   input channel: i_valid with the nine Q8.8 elements i_m00..i_m22, o_stall back
//   output channel: o_valid with the nine Q16.16 elements o_r00..o_r22, o_singular
//   and o_clipped, i_stall back; a transaction completes when valid is high and
//   stall is low at a rising edge
//   pipeline: the result passes through 39 register stages: 4 cofactor/determinant
//   stages, 1 divider prep stage, 33 restoring division stages (one quotient bit
//   each) and 1 saturation stage
//   throughput: one matrix per cycle while the receiver does not stall; all nine
//   divisions share the determinant and each bit stage holds one item
//   reset (synchronous, active low) clears every stage's valid bit; the data
//   registers are not reset
//   when the receiver stalls with a result waiting, the whole pipeline holds and
//   o_stall goes high in the same cycle; nothing is dropped or repeated
//   a zero determinant gives all-zero elements with o_singular set
`default_nettype none
module matrix_3x3_inverse_core import mi3_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [IN_W-1:0]     i_m00,
    input  wire logic [IN_W-1:0]     i_m01,
    input  wire logic [IN_W-1:0]     i_m02,
    input  wire logic [IN_W-1:0]     i_m10,
    input  wire logic [IN_W-1:0]     i_m11,
    input  wire logic [IN_W-1:0]     i_m12,
    input  wire logic [IN_W-1:0]     i_m20,
    input  wire logic [IN_W-1:0]     i_m21,
    input  wire logic [IN_W-1:0]     i_m22,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [RES_W-1:0]         o_r00,
    output logic [RES_W-1:0]         o_r01,
    output logic [RES_W-1:0]         o_r02,
    output logic [RES_W-1:0]         o_r10,
    output logic [RES_W-1:0]         o_r11,
    output logic [RES_W-1:0]         o_r12,
    output logic [RES_W-1:0]         o_r20,
    output logic [RES_W-1:0]         o_r21,
    output logic [RES_W-1:0]         o_r22,
    output logic                     o_singular,
    output logic                     o_clipped
);

    logic                w_en;
    logic [DEPTH-1:0]    r_vld;
    t_mat                w_m;
    t_cof                w_cof;
    logic [DET_W-1:0]    w_det;
    t_dstage             w_st [NSTEP+1];
    t_res                w_res;

    // whole pipeline advances unless a finished result is held by the receiver
    assign w_en    = !(r_vld[DEPTH-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[DEPTH-1];

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    assign w_m = {i_m22, i_m21, i_m20, i_m12, i_m11, i_m10, i_m02, i_m01, i_m00};

    mi3_cofactor u_cofactor (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_m   (w_m),
        .o_cof (w_cof),
        .o_det (w_det)
    );

    mi3_div_prep u_div_prep (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cof (w_cof),
        .i_det (w_det),
        .o_st  (w_st[0])
    );

    // one quotient bit per stage
    genvar g;
    generate
        for (g = 0; g < NSTEP; g++) begin : g_step
            mi3_div_step u_div_step (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_st  (w_st[g]),
                .o_st  (w_st[g+1])
            );
        end
    endgenerate

    mi3_sat u_sat (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_st       (w_st[NSTEP]),
        .o_res      (w_res),
        .o_singular (o_singular),
        .o_clipped  (o_clipped)
    );

    assign o_r00 = w_res[0];
    assign o_r01 = w_res[1];
    assign o_r02 = w_res[2];
    assign o_r10 = w_res[3];
    assign o_r11 = w_res[4];
    assign o_r12 = w_res[5];
    assign o_r20 = w_res[6];
    assign o_r21 = w_res[7];
    assign o_r22 = w_res[8];

    // the pipeline only holds back the sender while a result is waiting
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input held off with no result waiting");

    // an item in the last division stage reaches the output when the pipeline moves
    a_last_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[DEPTH-2] && w_en) |=> o_valid)
        else $error("item lost between divider and output");

    // a singular matrix gives zeros and no clip
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (!o_clipped && o_r00 == '0 && o_r01 == '0
            && o_r02 == '0 && o_r10 == '0 && o_r11 == '0 && o_r12 == '0
            && o_r20 == '0 && o_r21 == '0 && o_r22 == '0))
        else $error("singular result not cleared");

endmodule
`default_nettype wire

// File: dv/matrix_3x3_inverse_core_tb.sv
// matrix_3x3_inverse_core_tb: self-checking bench for the 3x3 matrix inverse pipeline
// depends on mi3_pkg and matrix_3x3_inverse_core; predicts each inverse and checks
// every result transaction in order under random gaps and stalls on both sides
`default_nettype none

class inverse_scoreboard;
    mi3_pkg::t_res  exp_elem_q[$];
    bit             exp_sing_q[$];
    bit             exp_clip_q[$];
    int             n_mismatch;

    function new();
        n_mismatch = 0;
    endfunction

    // exact adjugate inverse, truncated toward zero, saturated to 32 bits
    function void note_matrix(mi3_pkg::t_mat m);
        longint a[9];
        longint adj[9];
        longint det;
        longint q;
        mi3_pkg::t_res r;
        bit clip;
        clip = 0;
        r = '0;
        for (int i = 0; i < 9; i++) a[i] = longint'($signed(m[i]));
        adj[0] = a[4]*a[8] - a[5]*a[7];
        adj[1] = a[2]*a[7] - a[1]*a[8];
        adj[2] = a[1]*a[5] - a[2]*a[4];
        adj[3] = a[5]*a[6] - a[3]*a[8];
        adj[4] = a[0]*a[8] - a[2]*a[6];
        adj[5] = a[3]*a[2] - a[0]*a[5];
        adj[6] = a[3]*a[7] - a[4]*a[6];
        adj[7] = a[6]*a[1] - a[0]*a[7];
        adj[8] = a[0]*a[4] - a[3]*a[1];
        det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
        if (det != 0) begin
            for (int i = 0; i < 9; i++) begin
                q = (adj[i] * 64'sd16777216) / det;
                if (q > 64'sd2147483647) begin
                    q = 64'sd2147483647;
                    clip = 1;
                end else if (q < -64'sd2147483648) begin
                    q = -64'sd2147483648;
                    clip = 1;
                end
                r[i] = q[31:0];
            end
        end
        exp_elem_q.push_back(r);
        exp_sing_q.push_back(det == 0);
        exp_clip_q.push_back(clip);
    endfunction

    function void report(string what, longint e, longint g);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("mismatch %s: expected %h got %h", what, e, g);
    endfunction

    function void check_result(mi3_pkg::t_res r, bit sing, bit clip);
        mi3_pkg::t_res er;
        if (exp_elem_q.size() == 0) begin
            report("unexpected transaction", 0, 0);
            return;
        end
        er = exp_elem_q.pop_front();
        for (int i = 0; i < 9; i++)
            if (er[i] !== r[i]) report($sformatf("r%0d%0d", i/3, i%3), er[i], r[i]);
        if (exp_sing_q[0] !== sing) report("singular", exp_sing_q[0], sing);
        if (exp_clip_q[0] !== clip) report("clipped", exp_clip_q[0], clip);
        void'(exp_sing_q.pop_front());
        void'(exp_clip_q.pop_front());
    endfunction
endclass

module matrix_3x3_inverse_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mi3_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 1;
    logic o_stall, o_valid, o_singular, o_clipped;
    t_mat mat = '0;
    t_res res;
    bit send_done = 0;
    inverse_scoreboard sb = new();

    always #1 i_clk = ~i_clk;

    matrix_3x3_inverse_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_m00(mat[0]), .i_m01(mat[1]), .i_m02(mat[2]),
        .i_m10(mat[3]), .i_m11(mat[4]), .i_m12(mat[5]),
        .i_m20(mat[6]), .i_m21(mat[7]), .i_m22(mat[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_r00(res[0]), .o_r01(res[1]), .o_r02(res[2]),
        .o_r10(res[3]), .o_r11(res[4]), .o_r12(res[5]),
        .o_r20(res[6]), .o_r21(res[7]), .o_r22(res[8]),
        .o_singular(o_singular), .o_clipped(o_clipped)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    // one input transaction with an optional idle gap first; valid drops only in a gap
    task automatic send_matrix(t_mat m, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1;
        mat <= m;
        do @(posedge i_clk); while (o_stall);
        sb.note_matrix(m);
    endtask

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 1024)) - 512);
            3: return $urandom_range(0, 1) ? 16'h0100 : 16'hFF00;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_mat rand_matrix();
        t_mat m;
        int k;
        for (int i = 0; i < 9; i++) m[i] = rand_elem();
        k = $urandom_range(0, 9);
        // force singular by repeating a row, or use a scaled identity-ish matrix
        if (k == 0) for (int i = 0; i < 3; i++) m[3+i] = m[i];
        else if (k == 1) begin
            m = '0;
            for (int i = 0; i < 3; i++) m[4*i] = 16'($urandom_range(1, 8));
        end
        return m;
    endfunction

    function automatic t_mat diag(logic [15:0] v);
        t_mat m;
        m = '0;
        m[0] = v; m[4] = v; m[8] = v;
        return m;
    endfunction

    // stimulus
    initial begin
        t_mat m;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_matrix(diag(16'h0100), 0);
        send_matrix(diag(16'hFF00), 0);
        send_matrix(diag(16'h0001), 0);
        send_matrix(diag(16'h7FFF), 0);
        send_matrix(diag(16'h8000), 0);
        send_matrix('0, 0);
        send_matrix({9{16'hFFFF}}, 0);
        send_matrix({9{16'h8000}}, 0);
        m = '0; m[2] = 16'h0100; m[4] = 16'h0100; m[6] = 16'h0100;
        send_matrix(m, 0);
        m = '0; m[0] = 16'h7FFF; m[4] = 16'h8000; m[8] = 16'h0001;
        send_matrix(m, 0);
        m = '0; m[0] = 16'h0001; m[1] = 16'h7FFF; m[4] = 16'h0001; m[8] = 16'h0001;
        send_matrix(m, 0);
        m = '0; m[0] = 16'h8000; m[1] = 16'h7FFF; m[3] = 16'h7FFF;
        m[4] = 16'h8000; m[8] = 16'h0001;
        send_matrix(m, 0);
        send_matrix({16'h0900, 16'h0800, 16'h0700, 16'h0600, 16'h0500,
                     16'h0400, 16'h0300, 16'h0200, 16'h0100}, 0);
        for (int n = 0; n < 1750; n++) begin
            if (n == 900) begin
                // drain everything before sending more
                i_valid <= 0;
                @(posedge i_clk);
                while (sb.exp_elem_q.size() != 0) @(posedge i_clk);
            end
            send_matrix(rand_matrix(), (n % 400) >= 100);
        end
        i_valid <= 0;
        send_done = 1;
    end

    // receiver with random stalls, plus checking
    initial begin
        int s;
        s = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall)
                sb.check_result(res, o_singular, o_clipped);
            if (s > 0) s--;
            else if (($urandom_range(0, 9) < 3) && ($urandom_range(0, 3) != 0))
                s = gap_len();
            i_stall <= (s > 0);
        end
    end

    // end of run
    initial begin
        wait (send_done);
        while (sb.exp_elem_q.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 10) @(posedge i_clk);
        if (sb.n_mismatch == 0 && sb.exp_elem_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
